/* rtl/seawater_spiciness_poly_top_macros.svh */
`ifndef SEAWATER_SPICINESS_POLY_TOP_MACROS_SVH
`define SEAWATER_SPICINESS_POLY_TOP_MACROS_SVH

// Both macros expect i_clk and i_rst_n in the enclosing module.
`define SSP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SSP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ssp_pkg.sv */
package ssp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_FRAC     = 34;
    localparam int AW            = 64;
    localparam int SPLIT_W       = 32;
    localparam int T_W           = 23;
    localparam int S_W           = 22;
    localparam int Y_W           = 22;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 24;
    localparam int T_POW         = 6;
    localparam int S_POW         = 5;

    typedef logic signed [AW-1:0] t_acc;

    localparam int COEF_MANT [T_POW][S_POW] = '{
        '{0, 77442, -585, -984, -206},
        '{51655, 2034, -2742, -85, 136},
        '{664783, -24681, -1428, 3337, 7894},
        '{-54023, 7326, 70036, -30412, -10853},
        '{3949, -3029, -38209, 10012, 47133},
        '{-636, -1309, 6048, -11409, -6676}
    };

    localparam int COEF_DEXP [T_POW][S_POW] = '{
        '{0, 5, 5, 6, 6},
        '{6, 6, 7, 7, 7},
        '{8, 8, 8, 8, 9},
        '{9, 9, 10, 10, 10},
        '{10, 11, 11, 11, 12},
        '{12, 12, 12, 13, 13}
    };

    // Rounds m * 2^e / 10^k half away from zero by restoring long division.
    function automatic t_acc make_coef(int m, int k, int e);
        longint unsigned d;
        longint unsigned um;
        longint unsigned q;
        longint unsigned r;
        int n;
        d  = 1;
        for (n = 0; n < k; n++) begin
            d = d * 10;
        end
        um = (m < 0) ? longint'(-m) : longint'(m);
        q  = 0;
        r  = 0;
        for (n = 31; n >= 0; n--) begin
            r = (r << 1) | ((um >> n) & 64'd1);
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q + 1;
            end
        end
        for (n = 0; n < e; n++) begin
            q = q << 1;
            r = r << 1;
            if (r >= d) begin
                r = r - d;
                q = q + 1;
            end
        end
        if ((r << 1) >= d) begin
            q = q + 1;
        end
        return (m < 0) ? t_acc'(-q) : t_acc'(q);
    endfunction

    function automatic t_acc coef_val(int i, int j);
        return make_coef(COEF_MANT[i][j], COEF_DEXP[i][j], COEF_FRAC + 6 * (i + j));
    endfunction

endpackage

/* rtl/ssp_front.sv */
module ssp_front #(
    parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [ssp_pkg::T_W-1:0] i_temperature,
    input  logic [ssp_pkg::S_W-1:0]        i_salinity,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [FRAC_BITS+6:0]   o_tc,
    output logic signed [FRAC_BITS+6:0]   o_sc
);

    localparam int NORM = FRAC_BITS + 6;
    localparam int XW   = NORM + 1;
    localparam int CW   = (NORM + 2 > ssp_pkg::T_W + 1) ? NORM + 2 : ssp_pkg::T_W + 1;
    localparam logic signed [CW-1:0] LIM_HI = CW'((64'sd1 <<< NORM) - 64'sd1);
    localparam logic signed [CW-1:0] LIM_LO = CW'(-(64'sd1 <<< NORM));
    localparam logic signed [CW-1:0] S_OFS  = CW'(64'sd35 <<< FRAC_BITS);

    logic                 r_v;
    logic signed [XW-1:0] r_tc;
    logic signed [XW-1:0] r_sc;
    logic signed [CW-1:0] w_t;
    logic signed [CW-1:0] w_s;
    logic signed [XW-1:0] n_tc;
    logic signed [XW-1:0] n_sc;
    logic                 w_rdy;

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_v;
    assign o_tc    = r_tc;
    assign o_sc    = r_sc;

    always_comb begin
        w_t = CW'(i_temperature);
        w_s = signed'(CW'(i_salinity)) - S_OFS;
        if (w_t > LIM_HI) begin
            n_tc = XW'(LIM_HI);
        end else if (w_t < LIM_LO) begin
            n_tc = XW'(LIM_LO);
        end else begin
            n_tc = XW'(w_t);
        end
        if (w_s > LIM_HI) begin
            n_sc = XW'(LIM_HI);
        end else if (w_s < LIM_LO) begin
            n_sc = XW'(LIM_LO);
        end else begin
            n_sc = XW'(w_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_tc <= n_tc;
            r_sc <= n_sc;
        end
    end

endmodule

/* rtl/ssp_cell.sv */
`include "seawater_spiciness_poly_top_macros.svh"

module ssp_cell #(
    parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF,
    parameter int LANES     = 1,
    parameter int SIDE_W    = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  ssp_pkg::t_acc               i_acc [LANES],
    input  ssp_pkg::t_acc               i_add [LANES],
    input  logic signed [FRAC_BITS+6:0] i_x,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output ssp_pkg::t_acc               o_acc [LANES],
    output logic signed [FRAC_BITS+6:0] o_x,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int AW   = ssp_pkg::AW;
    localparam int LW   = ssp_pkg::SPLIT_W;
    localparam int HW   = AW - LW;
    localparam int NORM = FRAC_BITS + 6;
    localparam int XW   = NORM + 1;
    localparam int PW   = AW + XW + 1;
    localparam logic [PW-1:0] HALF = PW'(1) << (NORM - 1);

    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_rdy4;
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    logic [AW-1:0]        n_s1_ua  [LANES];
    logic                 n_s1_neg [LANES];
    logic [XW-1:0]        n_s1_ux;
    logic [AW-1:0]        r_s1_ua  [LANES];
    logic                 r_s1_neg [LANES];
    logic [XW-1:0]        r_s1_ux;
    ssp_pkg::t_acc        r_s1_add [LANES];
    logic signed [XW-1:0] r_s1_x;
    logic [SIDE_W-1:0]    r_s1_side;

    logic [HW+XW-1:0]     n_s2_phi [LANES];
    logic [LW+XW-1:0]     n_s2_plo [LANES];
    logic [HW+XW-1:0]     r_s2_phi [LANES];
    logic [LW+XW-1:0]     r_s2_plo [LANES];
    logic                 r_s2_neg [LANES];
    ssp_pkg::t_acc        r_s2_add [LANES];
    logic signed [XW-1:0] r_s2_x;
    logic [SIDE_W-1:0]    r_s2_side;

    logic [AW-1:0]        n_s3_r   [LANES];
    logic [AW-1:0]        r_s3_r   [LANES];
    logic                 r_s3_neg [LANES];
    ssp_pkg::t_acc        r_s3_add [LANES];
    logic signed [XW-1:0] r_s3_x;
    logic [SIDE_W-1:0]    r_s3_side;

    ssp_pkg::t_acc        n_s4_acc [LANES];
    ssp_pkg::t_acc        r_s4_acc [LANES];
    logic signed [XW-1:0] r_s4_x;
    logic [SIDE_W-1:0]    r_s4_side;

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v4;
    assign o_acc   = r_s4_acc;
    assign o_x     = r_s4_x;
    assign o_side  = r_s4_side;

    always_comb begin
        n_s1_ux = i_x[XW-1] ? XW'(~i_x + 1'b1) : XW'(i_x);
        for (int l = 0; l < LANES; l++) begin
            n_s1_ua[l]  = i_acc[l][AW-1] ? AW'(~i_acc[l] + 1'b1) : AW'(i_acc[l]);
            n_s1_neg[l] = i_acc[l][AW-1] ^ i_x[XW-1];
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_s2_phi[l] = r_s1_ua[l][AW-1:LW] * r_s1_ux;
            n_s2_plo[l] = r_s1_ua[l][LW-1:0] * r_s1_ux;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_s3_r[l] = AW'((PW'({r_s2_phi[l], {LW{1'b0}}}) + PW'(r_s2_plo[l]) + HALF)
                            >> NORM);
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_s4_acc[l] = r_s3_neg[l] ? ssp_pkg::t_acc'(r_s3_add[l] - r_s3_r[l])
                                      : ssp_pkg::t_acc'(r_s3_add[l] + r_s3_r[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_ua   <= n_s1_ua;
            r_s1_neg  <= n_s1_neg;
            r_s1_ux   <= n_s1_ux;
            r_s1_add  <= i_add;
            r_s1_x    <= i_x;
            r_s1_side <= i_side;
        end
        if (w_rdy2) begin
            r_s2_phi  <= n_s2_phi;
            r_s2_plo  <= n_s2_plo;
            r_s2_neg  <= r_s1_neg;
            r_s2_add  <= r_s1_add;
            r_s2_x    <= r_s1_x;
            r_s2_side <= r_s1_side;
        end
        if (w_rdy3) begin
            r_s3_r    <= n_s3_r;
            r_s3_neg  <= r_s2_neg;
            r_s3_add  <= r_s2_add;
            r_s3_x    <= r_s2_x;
            r_s3_side <= r_s2_side;
        end
        if (w_rdy4) begin
            r_s4_acc  <= n_s4_acc;
            r_s4_x    <= r_s3_x;
            r_s4_side <= r_s3_side;
        end
    end

    `SSP_ASSERT_IMP(a_blocked_only_when_full, !o_ready, r_v1 && r_v2 && r_v3 && r_v4 && !i_ready, "Cell refused an item while a stage was empty.")
    `SSP_ASSERT_NXT(a_zero_factor_product, r_v1 && w_rdy2 && r_s1_ux == '0, r_s2_phi[0] == '0 && r_s2_plo[0] == '0, "Zero factor gave a nonzero product.")
    `SSP_ASSERT_NXT(a_zero_term_keeps_addend, r_v3 && w_rdy4 && r_s3_r[0] == '0, r_s4_acc[0] == $past(r_s3_add[0]), "Zero product term changed the addend.")

endmodule

/* rtl/ssp_out.sv */
module ssp_out #(
    parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  ssp_pkg::t_acc                  i_acc,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ssp_pkg::Y_W-1:0]        o_y,
    output logic                           o_sat
);

    localparam int AW = ssp_pkg::AW;
    localparam int YW = ssp_pkg::Y_W;
    localparam int SH = ssp_pkg::COEF_FRAC - FRAC_BITS;
    localparam int UW = AW + 1 - SH;
    localparam logic [AW:0]   HALF  = (AW + 1)'(1) << (SH - 1);
    localparam logic [UW-1:0] U_MAX = UW'((64'd1 << (YW - 1)) - 64'd1);
    localparam logic [UW-1:0] U_MIN = UW'(64'd1 << (YW - 1));
    localparam logic [YW-1:0] Y_MAX = YW'(U_MAX);
    localparam logic [YW-1:0] Y_MIN = YW'(U_MIN);

    logic          w_rdy_a;
    logic          w_rdy_b;
    logic          r_va;
    logic          r_vb;
    logic [AW:0]   n_a_sum;
    logic [UW-1:0] r_a_u;
    logic          r_a_neg;
    logic [YW-1:0] n_b_y;
    logic          n_b_sat;
    logic [YW-1:0] r_b_y;
    logic          r_b_sat;

    assign w_rdy_b = !r_vb || i_ready;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;
    assign o_valid = r_vb;
    assign o_y     = r_b_y;
    assign o_sat   = r_b_sat;

    always_comb begin
        n_a_sum = (i_acc[AW-1] ? {1'b0, ~i_acc} : {1'b0, i_acc})
                  + (AW + 1)'(i_acc[AW-1]) + HALF;
    end

    always_comb begin
        if (!r_a_neg && r_a_u > U_MAX) begin
            n_b_y   = Y_MAX;
            n_b_sat = 1'b1;
        end else if (r_a_neg && r_a_u > U_MIN) begin
            n_b_y   = Y_MIN;
            n_b_sat = 1'b1;
        end else if (r_a_neg) begin
            n_b_y   = YW'(~r_a_u[YW-1:0] + 1'b1);
            n_b_sat = 1'b0;
        end else begin
            n_b_y   = r_a_u[YW-1:0];
            n_b_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_va <= i_valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_u   <= UW'(n_a_sum >> SH);
            r_a_neg <= i_acc[AW-1];
        end
        if (w_rdy_b) begin
            r_b_y   <= n_b_y;
            r_b_sat <= n_b_sat;
        end
    end

endmodule

/* rtl/seawater_spiciness_poly_top.sv */
// Surface seawater spiciness from one temperature and one salinity sample.
// Items enter on the slave stream (i_s_axis_*): tdata carries temperature and
// salinity, both fixed point with FRAC_BITS fraction bits. Results leave on the
// master stream (o_m_axis_*): tdata carries spiciness, tuser the clip flag.
// The block is fully pipelined and takes one item per clock cycle unless a
// stalled receiver has filled it. An item passes 39 register stages: one of
// input clamping, nine Horner cells of four stages each (four cells that
// evaluate the six salinity polynomials side by side, then five cells over
// temperature), and two of rounding and clipping.
// Each stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so a stalled receiver only stops the pipeline once every
// stage holds an item; until then new items are still taken.
// Reset clears all valid bits and drops any item in flight; results are held
// on the master stream until the receiver takes them.
module seawater_spiciness_poly_top #(
    parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // temperature [22:0], salinity [44:23], zero [47:45]
    input  logic [ssp_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // spiciness [21:0], zero [23:22]
    output logic [ssp_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // saturated [0]
    output logic [0:0]                        o_m_axis_tuser
);

    localparam int AW  = ssp_pkg::AW;
    localparam int XW  = FRAC_BITS + 7;
    localparam int NIN = 4;
    localparam int NOUT = 5;
    localparam int NL  = ssp_pkg::T_POW;

    logic                 w_iv   [NIN+1];
    logic                 w_ir   [NIN+1];
    ssp_pkg::t_acc        w_iacc [NIN+1][NL];
    ssp_pkg::t_acc        w_iadd [NIN][NL];
    logic signed [XW-1:0] w_ix   [NIN+1];
    logic [XW-1:0]        w_iside[NIN+1];

    logic                 w_ov   [NOUT+1];
    logic                 w_or   [NOUT+1];
    ssp_pkg::t_acc        w_oacc [NOUT+1][1];
    ssp_pkg::t_acc        w_oadd [NOUT][1];
    logic signed [XW-1:0] w_ox   [NOUT+1];
    logic [4*AW-1:0]      w_os   [NOUT+1];

    logic signed [XW-1:0]         w_tc;
    logic [ssp_pkg::Y_W-1:0]      w_y;
    logic                         w_sat;

    ssp_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_temperature(i_s_axis_tdata[ssp_pkg::T_W-1:0]),
        .i_salinity   (i_s_axis_tdata[ssp_pkg::T_W +: ssp_pkg::S_W]),
        .o_valid      (w_iv[0]),
        .i_ready      (w_ir[0]),
        .o_tc         (w_tc),
        .o_sc         (w_ix[0])
    );

    assign w_iside[0] = w_tc;

    genvar gk, gl;
    generate
        for (gl = 0; gl < NL; gl++) begin : g_init
            localparam ssp_pkg::t_acc C_TOP = ssp_pkg::coef_val(gl, ssp_pkg::S_POW - 1);
            assign w_iacc[0][gl] = C_TOP;
        end

        for (gk = 0; gk < NIN; gk++) begin : g_sal
            for (gl = 0; gl < NL; gl++) begin : g_lane
                localparam ssp_pkg::t_acc C_ADD = ssp_pkg::coef_val(gl, NIN - 1 - gk);
                assign w_iadd[gk][gl] = C_ADD;
            end
            ssp_cell #(
                .FRAC_BITS(FRAC_BITS),
                .LANES    (NL),
                .SIDE_W   (XW)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_valid(w_iv[gk]),
                .o_ready(w_ir[gk]),
                .i_acc  (w_iacc[gk]),
                .i_add  (w_iadd[gk]),
                .i_x    (w_ix[gk]),
                .i_side (w_iside[gk]),
                .o_valid(w_iv[gk+1]),
                .i_ready(w_ir[gk+1]),
                .o_acc  (w_iacc[gk+1]),
                .o_x    (w_ix[gk+1]),
                .o_side (w_iside[gk+1])
            );
        end
    endgenerate

    assign w_ov[0]      = w_iv[NIN];
    assign w_ir[NIN]    = w_or[0];
    assign w_oacc[0][0] = w_iacc[NIN][NL-1];
    assign w_oadd[0][0] = w_iacc[NIN][NL-2];
    assign w_ox[0]      = signed'(w_iside[NIN]);
    assign w_os[0]      = {w_iacc[NIN][3], w_iacc[NIN][2], w_iacc[NIN][1], w_iacc[NIN][0]};

    generate
        for (gk = 0; gk < NOUT; gk++) begin : g_tmp
            if (gk > 0) begin : g_add
                assign w_oadd[gk][0] = ssp_pkg::t_acc'(w_os[gk][(NOUT-1-gk)*AW +: AW]);
            end
            ssp_cell #(
                .FRAC_BITS(FRAC_BITS),
                .LANES    (1),
                .SIDE_W   (4 * AW)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_valid(w_ov[gk]),
                .o_ready(w_or[gk]),
                .i_acc  (w_oacc[gk]),
                .i_add  (w_oadd[gk]),
                .i_x    (w_ox[gk]),
                .i_side (w_os[gk]),
                .o_valid(w_ov[gk+1]),
                .i_ready(w_or[gk+1]),
                .o_acc  (w_oacc[gk+1]),
                .o_x    (w_ox[gk+1]),
                .o_side (w_os[gk+1])
            );
        end
    endgenerate

    ssp_out #(
        .FRAC_BITS(FRAC_BITS)
    ) u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_ov[NOUT]),
        .o_ready(w_or[NOUT]),
        .i_acc  (w_oacc[NOUT][0]),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_y    (w_y),
        .o_sat  (w_sat)
    );

    assign o_m_axis_tdata = {{(ssp_pkg::OUT_TDATA_W - ssp_pkg::Y_W){1'b0}}, w_y};
    assign o_m_axis_tuser = w_sat;

endmodule

/* verif/seawater_spiciness_poly_top_tb.sv */
`timescale 1ns / 100ps

module seawater_spiciness_poly_top_tb;

    localparam int FB          = ssp_pkg::FRAC_BITS_DEF;
    localparam int NORM        = FB + 6;
    localparam int Q_COEF      = 34;
    localparam longint Y_MAX   = 64'sd2097151;
    localparam longint Y_MIN   = -64'sd2097152;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1000;
    localparam int N_DIRECTED  = 20;

    localparam int POLY_MANT [6][5] = '{
        '{0, 77442, -585, -984, -206},
        '{51655, 2034, -2742, -85, 136},
        '{664783, -24681, -1428, 3337, 7894},
        '{-54023, 7326, 70036, -30412, -10853},
        '{3949, -3029, -38209, 10012, 47133},
        '{-636, -1309, 6048, -11409, -6676}
    };

    localparam int POLY_DEXP [6][5] = '{
        '{0, 5, 5, 6, 6},
        '{6, 6, 7, 7, 7},
        '{8, 8, 8, 8, 9},
        '{9, 9, 10, 10, 10},
        '{10, 11, 11, 11, 12},
        '{12, 12, 12, 13, 13}
    };

    localparam int DIR_TEMP [N_DIRECTED] = '{
        -262144, -262144, 2621440, 2621440, 0, 0, 1, -1, 1310720, 4194303,
        -4194304, 4194303, -4194304, -4194304, 4194303, 2796202, -2796203,
        655360, -65536, 2000000
    };

    localparam int DIR_SAL [N_DIRECTED] = '{
        0, 2752512, 0, 2752512, 2293760, 0, 2293760, 2293760, 2293760, 2293760,
        2293760, 0, 0, 4194303, 4194303, 1398101, 2796202,
        4194303, 1, 2293761
    };

    typedef struct packed {
        logic signed [21:0] spice;
        logic               clip;
    } t_spice_res;

    class t_spice_scoreboard;
        longint     coef [6][5];
        t_spice_res expected_spice [$];
        int         errors;

        function new();
            errors = 0;
            for (int i = 0; i < 6; i++) begin
                for (int j = 0; j < 5; j++) begin
                    coef[i][j] = scaled_coef(POLY_MANT[i][j], POLY_DEXP[i][j],
                                             Q_COEF + 6 * (i + j));
                end
            end
        endfunction

        // m * 2^e / 10^k, rounded half away from zero.
        function longint scaled_coef(int m, int k, int e);
            logic [127:0] num;
            logic [127:0] den;
            logic [127:0] q;
            logic [127:0] r;
            den = 1;
            for (int n = 0; n < k; n++) begin
                den = den * 10;
            end
            num = (m < 0) ? -m : m;
            num = num << e;
            q = num / den;
            r = num % den;
            if ((r << 1) >= den) begin
                q = q + 1;
            end
            return (m < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
        endfunction

        function longint scaled_mul(longint a, longint x);
            logic [127:0] ua;
            logic [127:0] ux;
            logic [127:0] p;
            ua = (a < 0) ? -a : a;
            ux = (x < 0) ? -x : x;
            p = (ua * ux + (128'd1 << (NORM - 1))) >> NORM;
            return ((a < 0) != (x < 0)) ? -$signed(p[63:0]) : $signed(p[63:0]);
        endfunction

        function t_spice_res spice_poly(logic signed [22:0] temp, logic [21:0] sal);
            longint lim;
            longint tc;
            longint sc;
            longint acc;
            longint mag;
            longint y;
            longint cpoly [6];
            t_spice_res res;
            lim = longint'(64) << FB;
            tc = temp;
            sc = sal;
            sc = sc - (longint'(35) << FB);
            if (tc < -lim) tc = -lim;
            if (tc > lim - 1) tc = lim - 1;
            if (sc < -lim) sc = -lim;
            if (sc > lim - 1) sc = lim - 1;
            for (int i = 0; i < 6; i++) begin
                acc = coef[i][4];
                for (int j = 3; j >= 0; j--) begin
                    acc = scaled_mul(acc, sc) + coef[i][j];
                end
                cpoly[i] = acc;
            end
            acc = cpoly[5];
            for (int i = 4; i >= 0; i--) begin
                acc = scaled_mul(acc, tc) + cpoly[i];
            end
            mag = (acc < 0) ? -acc : acc;
            mag = (mag + (longint'(1) << (Q_COEF - FB - 1))) >> (Q_COEF - FB);
            y = (acc < 0) ? -mag : mag;
            res.clip = 1'b0;
            if (y > Y_MAX) begin
                y = Y_MAX;
                res.clip = 1'b1;
            end else if (y < Y_MIN) begin
                y = Y_MIN;
                res.clip = 1'b1;
            end
            res.spice = y[21:0];
            return res;
        endfunction

        function void note_sample(logic signed [22:0] temp, logic [21:0] sal);
            expected_spice.push_back(spice_poly(temp, sal));
        endfunction

        function void check_result(logic signed [21:0] spice, logic clip);
            t_spice_res want;
            if (expected_spice.size() == 0) begin
                $error("Result with no item pending: spiciness %0d saturated %0d",
                       spice, clip);
                errors++;
            end else begin
                want = expected_spice.pop_front();
                if (spice !== want.spice) begin
                    $error("spiciness: expected %0d, actual %0d", want.spice, spice);
                    errors++;
                end
                if (clip !== want.clip) begin
                    $error("saturated: expected %0d, actual %0d", want.clip, clip);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    // temperature [22:0], salinity [44:23], zero [47:45]
    logic [ssp_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata = '0;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    // spiciness [21:0], zero [23:22]
    logic [ssp_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata;
    // saturated [0]
    logic [0:0]                        o_m_axis_tuser;

    t_spice_scoreboard sb;
    logic quiet = 1'b0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   rx_left = 0;
    int   cycle_count = 0;

    seawater_spiciness_poly_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            sb.note_sample(i_s_axis_tdata[22:0], i_s_axis_tdata[44:23]);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata[21:0], o_m_axis_tuser[0]);
        end
    end

    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            rx_left <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (rx_left > 0) begin
            rx_left <= rx_left - 1;
            if (rx_left == 1) begin
                i_m_axis_tready <= 1'b1;
            end
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            i_m_axis_tready <= 1'b0;
            rx_left <= idle_len();
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic send_sample(input logic signed [22:0] temp, input logic [21:0] sal);
        int gap;
        gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {3'b000, sal, temp};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_random();
        logic signed [22:0] temp;
        logic [21:0]        sal;
        if ($urandom_range(0, 9) < 7) begin
            temp = $urandom_range(0, 2883584) - 262144;
        end else begin
            temp = $urandom();
        end
        if ($urandom_range(0, 9) < 7) begin
            sal = $urandom_range(0, 2752512);
        end else begin
            sal = $urandom();
        end
        send_sample(temp, sal);
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_DIRECTED; n++) begin
            send_sample(DIR_TEMP[n], DIR_SAL[n]);
        end

        // The receiver stops for a long stretch while items keep coming in
        // back to back, so the pipeline fills and the input stalls.
        hold_requests <= hold_requests + 1;
        quiet <= 1'b1;
        for (int n = 0; n < 120; n++) begin
            send_random();
        end
        quiet <= 1'b0;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 100) begin
                quiet <= 1'b1;
            end else if (n % 200 == 160) begin
                quiet <= 1'b0;
            end
            send_random();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.expected_spice.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);

        if (sb.expected_spice.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_spice.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ssp_pkg.sv
rtl/ssp_front.sv
rtl/ssp_cell.sv
rtl/ssp_out.sv
rtl/seawater_spiciness_poly_top.sv
verif/seawater_spiciness_poly_top_tb.sv
